[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable and a fixed message.
`define SMN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, with a caller-supplied message.
`define SMN_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[hw/rtl/smn_pkg.sv]
// ---------------------------------------------------------------------------
// smn_pkg
// Field widths shared by the smooth number term generator.
// ---------------------------------------------------------------------------
package smn_pkg;

  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned NUM_CAND = 3;

endpackage

[hw/rtl/smn_intf.sv]
// ---------------------------------------------------------------------------
// smn_intf
// Request and response channels (valid/ready) of the term generator.
// ---------------------------------------------------------------------------
interface smn_req_if;
  import smn_pkg::*;

  logic                valid;
  logic                ready;
  logic [FACTOR_W-1:0] factor_a;
  logic [FACTOR_W-1:0] factor_b;
  logic [FACTOR_W-1:0] factor_c;
  logic [INDEX_W-1:0]  term_index;

  modport source (output valid, output factor_a, output factor_b, output factor_c,
                  output term_index, input ready);
  modport sink   (input valid, input factor_a, input factor_b, input factor_c,
                  input term_index, output ready);
endinterface

interface smn_rsp_if #(
  parameter int unsigned VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] term_value;
  logic                   overflow;

  modport source (output valid, output term_value, output overflow, input ready);
  modport sink   (input valid, input term_value, input overflow, output ready);
endinterface

[hw/rtl/smn_store.sv]
// ---------------------------------------------------------------------------
// smn_store
// Scratch sequence memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module smn_store #(
  parameter int unsigned DEPTH       = 4096,
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned AW          = 12
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [VALUE_WIDTH-1:0] wr_data_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic [VALUE_WIDTH-1:0] rd_data_o
);

  logic [VALUE_WIDTH-1:0] mem_q [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/smn_mul.sv]
// ---------------------------------------------------------------------------
// smn_mul
// Shared saturating multiplier: factor times stored term, result registered.
// ---------------------------------------------------------------------------
module smn_mul
  import smn_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [FACTOR_W-1:0]    factor_i,
  input  logic [VALUE_WIDTH-1:0] operand_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] prod_o,
  output logic                   sat_o
);

  localparam int unsigned PW = FACTOR_W + VALUE_WIDTH;

  logic [PW-1:0]          prod_full;
  logic                   prod_sat;
  logic                   done_q;
  logic [VALUE_WIDTH-1:0] prod_q;
  logic                   sat_q;

  assign prod_full = PW'(factor_i) * PW'(operand_i);
  // anything above the value width means the product does not fit
  assign prod_sat  = |prod_full[PW-1:VALUE_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_sat ? {VALUE_WIDTH{1'b1}} : prod_full[VALUE_WIDTH-1:0];
      sat_q  <= prod_sat;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;
  assign sat_o  = sat_q;

endmodule

[hw/rtl/smooth_number_nth_term.sv]
// ---------------------------------------------------------------------------
// smooth_number_nth_term
// n-th term of the ascending sequence generated by three factors, built by a
// three-candidate merge over a scratch memory with one shared multiplier.
// ---------------------------------------------------------------------------
//   channel  dir  beat contents
//   req_i    in   factor_a, factor_b, factor_c, term_index
//   rsp_o    out  term_value, overflow
//
// Per term: pick the least candidate and store it, then check each candidate
// in turn; a candidate that advances is read, multiplied and updated, all
// through the one memory read port and the one multiplier. After a result the
// block returns to idle before it takes the next request.
// req_i is ready only while idle; a finished result waits in the output
// register, and a new request is taken while it waits. Reset is asynchronous.
// ---------------------------------------------------------------------------
module smooth_number_nth_term
  import smn_pkg::*;
#(
  parameter int unsigned MAX_TERMS   = 4096,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  smn_req_if.sink    req_i,
  smn_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 2);
  localparam logic [CW-1:0] MaxN = CW'(MAX_TERMS);
  localparam logic [VALUE_WIDTH-1:0] VMask = {VALUE_WIDTH{1'b1}};
  localparam logic [1:0] LastSel = 2'(NUM_CAND - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PICK1 = 3'd1;
  localparam logic [2:0] ST_PICK2 = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]             state_q;
  logic [FACTOR_W-1:0]    fac_q  [NUM_CAND];
  logic [VALUE_WIDTH-1:0] cand_q [NUM_CAND];
  logic                   sat_q  [NUM_CAND];
  logic [CW-1:0]          ptr_q  [NUM_CAND];
  logic [1:0]             sel_q;
  logic [CW-1:0]          idx_q;
  logic [CW-1:0]          n_q;
  logic [VALUE_WIDTH-1:0] z_q;
  logic                   have_q;
  logic                   zsat_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_val_q;
  logic                   out_ovf_q;

  logic                   req_fire;
  logic [31:0]            req_n32;
  logic [CW-1:0]          n_clamp;
  logic                   all_sat;
  logic [VALUE_WIDTH-1:0] z_ab;
  logic                   have_ab;
  logic                   take_c;
  logic [VALUE_WIDTH-1:0] z_abc;
  logic                   adv_ok;
  logic                   out_load;

  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   mul_start;
  logic                   mul_done;
  logic [VALUE_WIDTH-1:0] mul_prod;
  logic                   mul_sat;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign req_n32 = 32'(req_i.term_index);
  assign n_clamp = (req_n32 > MAX_TERMS) ? MaxN : CW'(req_n32);

  // least unsaturated candidate, first one wins ties
  assign all_sat = sat_q[0] && sat_q[1] && sat_q[2];
  always_comb begin
    z_ab    = cand_q[0];
    have_ab = !sat_q[0];
    if (!sat_q[1] && (!have_ab || cand_q[1] < z_ab)) begin
      z_ab    = cand_q[1];
      have_ab = 1'b1;
    end
  end
  assign take_c = !sat_q[2] && (!have_q || cand_q[2] < z_q);
  assign z_abc  = take_c ? cand_q[2] : z_q;

  // advance only while not saturated, not above z, and reading stored terms
  assign adv_ok = !sat_q[sel_q] && (cand_q[sel_q] <= z_q) && (ptr_q[sel_q] <= idx_q);

  assign mem_we    = (state_q == ST_PICK2);
  assign mem_waddr = AW'(idx_q - CW'(1));
  assign mem_re    = (state_q == ST_CHK) && adv_ok;
  assign mem_raddr = AW'(ptr_q[sel_q] - CW'(1));
  assign mul_start = (state_q == ST_RD);

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);

  smn_store #(
    .DEPTH       (MAX_TERMS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (z_abc),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  smn_mul #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .factor_i  (fac_q[sel_q]),
    .operand_i (mem_rdata),
    .done_o    (mul_done),
    .prod_o    (mul_prod),
    .sat_o     (mul_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 2'd0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_CAND; k++) begin
        cand_q[k] <= '0;
        sat_q[k]  <= 1'b0;
        ptr_q[k]  <= CW'(1);
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            cand_q[0] <= VALUE_WIDTH'(req_i.factor_a);
            cand_q[1] <= VALUE_WIDTH'(req_i.factor_b);
            cand_q[2] <= VALUE_WIDTH'(req_i.factor_c);
            for (int k = 0; k < NUM_CAND; k++) begin
              sat_q[k] <= 1'b0;
              ptr_q[k] <= CW'(1);
            end
            if (n_clamp == '0) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_PICK1;
            end
          end
        end
        ST_PICK1: begin
          if (all_sat) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_PICK2;
          end
        end
        ST_PICK2: begin
          sel_q   <= 2'd0;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (adv_ok) begin
            state_q <= ST_RD;
          end else if (sel_q != LastSel) begin
            sel_q <= sel_q + 2'd1;
          end else if (idx_q == n_q) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_PICK1;
          end
        end
        ST_RD: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            cand_q[sel_q] <= mul_prod;
            sat_q[sel_q]  <= mul_sat;
            ptr_q[sel_q]  <= ptr_q[sel_q] + CW'(1);
            state_q       <= ST_CHK;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      fac_q[0] <= req_i.factor_a;
      fac_q[1] <= req_i.factor_b;
      fac_q[2] <= req_i.factor_c;
      n_q      <= n_clamp;
      idx_q    <= CW'(1);
      z_q      <= '0;
      zsat_q   <= 1'b0;
    end
    if (state_q == ST_PICK1) begin
      if (all_sat) begin
        z_q    <= VMask;
        zsat_q <= 1'b1;
      end else begin
        z_q    <= z_ab;
        have_q <= have_ab;
      end
    end
    if (state_q == ST_PICK2) begin
      z_q <= z_abc;
    end
    if (state_q == ST_CHK && !adv_ok && sel_q == LastSel && idx_q != n_q) begin
      idx_q <= idx_q + CW'(1);
    end
    if (out_load) begin
      out_val_q <= z_q;
      out_ovf_q <= zsat_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.term_value = out_val_q;
  assign rsp_o.overflow   = out_ovf_q;

endmodule

[hw/rtl/smn_checker.sv]
// ---------------------------------------------------------------------------
// smn_checker
// Port-level checks of the term generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smn_checker #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic [VALUE_WIDTH-1:0] rsp_value_i,
  input logic                   rsp_overflow_i
);

  // a pending result beat is held until taken
  `SMN_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)

  // a saturated term is always all ones
  `SMN_ASSERT_MSG(a_ovf_ones, clk_i, rst_ni, rsp_valid_i && rsp_overflow_i |-> rsp_value_i == {VALUE_WIDTH{1'b1}}, "overflow without saturated value")

  // the block is busy right after taking a request
  `SMN_ASSERT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i |=> !req_ready_i)

  // a new result appears only out of a busy cycle
  `SMN_ASSERT(a_rsp_from_busy, clk_i, rst_ni, $rose(rsp_valid_i) |-> $past(!req_ready_i))

endmodule

bind smooth_number_nth_term smn_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_smn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_value_i    (rsp_o.term_value),
  .rsp_overflow_i (rsp_o.overflow)
);

[dv/smooth_number_nth_term_test.sv]
// ---------------------------------------------------------------------------
// smooth_number_nth_term_test
// Self-checking bench for the smooth number term generator. A directed table
// (extremes, index zero, clamped index, factors 0 and 1, saturation) is
// followed by random requests in three idling phases. Every response beat is
// checked against a typed table value or an in-bench three-candidate merge.
// ---------------------------------------------------------------------------
module smooth_number_nth_term_test;
  timeunit 1ns;
  timeprecision 1ps;

  import smn_pkg::*;

  localparam int unsigned MAX_TERMS      = 4096;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned PROD_W         = VALUE_W + FACTOR_W;
  localparam int unsigned RAND_PER_PHASE = 26;
  localparam int unsigned HOLD_CYCLES    = 4000;
  localparam int unsigned SETTLE_CYCLES  = 64;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor_a;
    logic [FACTOR_W-1:0] factor_b;
    logic [FACTOR_W-1:0] factor_c;
    logic [INDEX_W-1:0]  term_index;
  } req_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } smooth_term_t;

  typedef struct packed {
    req_beat_t    req;
    logic         typed;
    smooth_term_t want;
  } table_row_t;

  logic clk;
  logic rst_n;

  smn_req_if                          req_if ();
  smn_rsp_if #(.VALUE_WIDTH(VALUE_W)) rsp_if ();

  smooth_number_nth_term #(
    .MAX_TERMS  (MAX_TERMS),
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  smooth_term_t     pending_terms[$];
  table_row_t       directed_rows[$];
  logic [VALUE_W-1:0] term_store[MAX_TERMS];
  int unsigned      fail_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      hold_len;
  int unsigned      big_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------
  // {saturated, product}; saturates when factor * value needs more than 64 bits
  function automatic logic [VALUE_W:0] saturating_product(logic [FACTOR_W-1:0] f,
                                                          logic [VALUE_W-1:0] x);
    logic [PROD_W-1:0] wide;
    wide = PROD_W'(f) * PROD_W'(x);
    if (|wide[PROD_W-1:VALUE_W]) begin
      return {1'b1, {VALUE_W{1'b1}}};
    end
    return {1'b0, wide[VALUE_W-1:0]};
  endfunction

  function automatic smooth_term_t predict_nth_term(req_beat_t r);
    logic [FACTOR_W-1:0] fac[3];
    logic [VALUE_W-1:0]  cand[3];
    logic                csat[3];
    int unsigned         rd[3];
    logic [VALUE_W-1:0]  z;
    logic                zsat;
    logic                have;
    logic                done;
    int unsigned         n;
    smooth_term_t        res;
    fac[0] = r.factor_a;
    fac[1] = r.factor_b;
    fac[2] = r.factor_c;
    n = 32'(r.term_index);
    if (n > MAX_TERMS) n = MAX_TERMS;
    z = '0;
    zsat = 1'b0;
    done = 1'b0;
    for (int k = 0; k < 3; k++) begin
      {csat[k], cand[k]} = saturating_product(fac[k], 64'd1);
      rd[k] = 1;
    end
    for (int unsigned i = 1; i <= n && !done; i++) begin
      if (csat[0] && csat[1] && csat[2]) begin
        // nothing left to merge: this term and all later ones saturate
        z = '1;
        zsat = 1'b1;
        done = 1'b1;
      end else begin
        have = 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (!csat[k] && (!have || cand[k] < z)) begin
            z = cand[k];
            have = 1'b1;
          end
        end
        term_store[i-1] = z;
        // advance only over terms already stored
        for (int k = 0; k < 3; k++) begin
          while (!csat[k] && cand[k] <= z && rd[k] <= i) begin
            {csat[k], cand[k]} = saturating_product(fac[k], term_store[rd[k]-1]);
            rd[k]++;
          end
        end
      end
    end
    res.value = z;
    res.overflow = zsat;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic logic [FACTOR_W-1:0] random_factor();
    int unsigned         pick;
    logic [FACTOR_W-1:0] f;
    pick = $urandom_range(0, 99);
    if (pick < 70)      f = FACTOR_W'($urandom_range(2, 16));
    else if (pick < 80) f = FACTOR_W'($urandom_range(17, 300));
    else if (pick < 95) f = FACTOR_W'($urandom_range(0, 65535));
    else                f = FACTOR_W'($urandom_range(0, 1));
    return f;
  endfunction

  // long indices are slow to compute, so only a handful are drawn
  function automatic req_beat_t random_request();
    int unsigned pick;
    req_beat_t   r;
    r.factor_a = random_factor();
    r.factor_b = random_factor();
    r.factor_c = random_factor();
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      r.term_index = INDEX_W'($urandom_range(1, 64));
    end else if (pick < 95) begin
      r.term_index = INDEX_W'($urandom_range(0, 400));
    end else if (big_left > 0) begin
      big_left--;
      r.term_index = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
    end else begin
      r.term_index = INDEX_W'($urandom_range(1, 32));
    end
    return r;
  endfunction

  function automatic void add_row(int unsigned a, int unsigned b, int unsigned c,
                                  int unsigned n, logic typed,
                                  logic [VALUE_W-1:0] value, logic ovf);
    table_row_t row;
    row.req.factor_a   = FACTOR_W'(a);
    row.req.factor_b   = FACTOR_W'(b);
    row.req.factor_c   = FACTOR_W'(c);
    row.req.term_index = INDEX_W'(n);
    row.typed          = typed;
    row.want.value     = value;
    row.want.overflow  = ovf;
    directed_rows.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_request(req_beat_t r, logic typed, smooth_term_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.factor_a   <= r.factor_a;
    req_if.factor_b   <= r.factor_b;
    req_if.factor_c   <= r.factor_c;
    req_if.term_index <= r.term_index;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    if (typed) pending_terms.push_back(want);
    else       pending_terms.push_back(predict_nth_term(r));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_terms.size() != 0) @(negedge clk);
  endtask

  initial begin
    smooth_term_t none;
    none = '0;
    fail_count    = 0;
    hold_len      = 0;
    big_left      = 4;
    send_idle_pct = 10;
    recv_idle_pct = 84;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.factor_a   = '0;
    req_if.factor_b   = '0;
    req_if.factor_c   = '0;
    req_if.term_index = '0;

    //      a      b      c      n     typed  value                    ovf
    add_row(2,     3,     5,     1,    1'b1,  64'd2,                   1'b0);
    add_row(2,     3,     5,     0,    1'b1,  64'd0,                   1'b0);
    add_row(65535, 65535, 65535, 1,    1'b1,  64'd65535,               1'b0);
    add_row(65535, 65535, 65535, 4,    1'b0,  '0,                      1'b0);
    add_row(65535, 65535, 65535, 5,    1'b1,  '1,                      1'b1);
    add_row(65535, 65535, 65535, 8191, 1'b1,  '1,                      1'b1);
    add_row(2,     2,     2,     63,   1'b1,  64'h8000_0000_0000_0000, 1'b0);
    add_row(2,     2,     2,     64,   1'b1,  '1,                      1'b1);
    add_row(0,     0,     0,     5,    1'b1,  64'd0,                   1'b0);
    add_row(1,     1,     1,     7,    1'b1,  64'd1,                   1'b0);
    add_row(2,     3,     5,     10,   1'b0,  '0,                      1'b0);
    add_row(0,     1,     2,     20,   1'b0,  '0,                      1'b0);
    add_row(1,     2,     3,     30,   1'b0,  '0,                      1'b0);
    add_row(0,     5,     0,     9,    1'b0,  '0,                      1'b0);
    add_row(1,     65535, 0,     300,  1'b0,  '0,                      1'b0);
    add_row(2,     4,     8,     30,   1'b0,  '0,                      1'b0);
    add_row(4,     6,     9,     40,   1'b0,  '0,                      1'b0);
    add_row(7,     7,     7,     23,   1'b0,  '0,                      1'b0);
    add_row(3,     5,     7,     50,   1'b0,  '0,                      1'b0);
    add_row(65535, 2,     65534, 100,  1'b0,  '0,                      1'b0);
    add_row(43690, 21845, 65535, 3,    1'b0,  '0,                      1'b0);
    add_row(2,     3,     65535, 2000, 1'b0,  '0,                      1'b0);
    add_row(2,     3,     5,     4096, 1'b0,  '0,                      1'b0);
    add_row(2,     3,     5,     8191, 1'b0,  '0,                      1'b0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    req_if.valid <= 1'b0;
    wait_drained();
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // output stalls long enough for the block to back up its input
          hold_len = HOLD_CYCLES;
        end
      endcase
      for (int unsigned j = 0; j < RAND_PER_PHASE; j++) begin
        send_request(random_request(), 1'b0, none);
      end
      req_if.valid <= 1'b0;
      wait_drained();
      @(negedge clk);
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_terms.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_taken && hold_len != 0) begin
        hold_taken = 1'b1;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    smooth_term_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_terms.size() == 0) begin
        if (fail_count < 10) begin
          $display("%0t: unexpected result beat value=%h ovf=%b",
                   $realtime, rsp_if.term_value, rsp_if.overflow);
        end
        fail_count++;
      end else begin
        want = pending_terms.pop_front();
        if (rsp_if.term_value !== want.value || rsp_if.overflow !== want.overflow) begin
          if (fail_count < 10) begin
            $display("%0t: term mismatch: expected value=%h ovf=%b, got value=%h ovf=%b",
                     $realtime, want.value, want.overflow,
                     rsp_if.term_value, rsp_if.overflow);
          end
          fail_count++;
        end
      end
    end
  end

endmodule
